// ===== src/ipc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipc_pkg
// shared widths, register indexes and the configuration bundle of the
// incremental pi controller
// ----------------------------------------------------------------------------
package ipc_pkg;

	localparam int GainW  = 24;
	localparam int ValW   = 16;
	localparam int ErrW   = ValW + 1;
	localparam int DiffW  = ValW + 2;
	localparam int FracW  = 16;
	localparam int AccW   = 45;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 24;

	localparam logic [CfgIdxW-1:0] RegKp       = 3'd0;
	localparam logic [CfgIdxW-1:0] RegKiTs     = 3'd1;
	localparam logic [CfgIdxW-1:0] RegSetpoint = 3'd2;
	localparam logic [CfgIdxW-1:0] RegOutMin   = 3'd3;
	localparam logic [CfgIdxW-1:0] RegOutMax   = 3'd4;

	localparam logic signed [ValW-1:0] OutMinReset = 16'sh8000;
	localparam logic signed [ValW-1:0] OutMaxReset = 16'sh7fff;

	typedef struct packed {
		logic signed [GainW-1:0] kp;
		logic signed [GainW-1:0] ki_ts;
		logic signed [ValW-1:0]  setpoint;
		logic signed [ValW-1:0]  out_min;
		logic signed [ValW-1:0]  out_max;
	} ipc_cfg_t;

	typedef struct packed {
		logic signed [ErrW-1:0] prev_error;
		logic signed [ValW-1:0] prev_drive;
		logic                   primed;
	} ipc_hist_t;

endpackage

// ===== src/ipc_calc.sv =====
// ----------------------------------------------------------------------------
// ipc_calc
// control law: q16 sum of the velocity form, clamp, truncation toward zero
// ----------------------------------------------------------------------------
module ipc_calc (
	input  ipc_pkg::ipc_cfg_t                cfg,
	input  ipc_pkg::ipc_hist_t               hist,
	input  logic signed [ipc_pkg::ErrW-1:0]  err,
	input  logic                             restart,
	output logic signed [ipc_pkg::ValW-1:0]  drive
);

	logic                                   has_hist;
	logic signed [ipc_pkg::DiffW-1:0]       kp_opd;
	logic signed [ipc_pkg::GainW+ipc_pkg::DiffW-1:0] kp_prod;
	logic signed [ipc_pkg::GainW+ipc_pkg::ErrW-1:0]  ki_prod;
	logic signed [ipc_pkg::AccW-1:0]        acc;
	logic signed [ipc_pkg::AccW-1:0]        hi_lim;
	logic signed [ipc_pkg::AccW-1:0]        lo_lim;
	logic [ipc_pkg::AccW-ipc_pkg::FracW-1:0] whole;
	logic [ipc_pkg::AccW-ipc_pkg::FracW-1:0] whole_tz;

	// restart drops the history before this sample is used
	assign has_hist = hist.primed && !restart;

	assign kp_opd = has_hist ?
		({err[ipc_pkg::ErrW-1], err} - {hist.prev_error[ipc_pkg::ErrW-1], hist.prev_error}) :
		{err[ipc_pkg::ErrW-1], err};

	assign kp_prod = cfg.kp * kp_opd;
	assign ki_prod = cfg.ki_ts * err;

	always_comb begin
		acc = {{(ipc_pkg::AccW - ipc_pkg::GainW - ipc_pkg::DiffW){kp_prod[$high(kp_prod)]}},
			kp_prod};
		if (has_hist) begin
			acc = acc
				+ {{(ipc_pkg::AccW - ipc_pkg::GainW - ipc_pkg::ErrW){ki_prod[$high(ki_prod)]}},
					ki_prod}
				+ {{(ipc_pkg::AccW - ipc_pkg::ValW - ipc_pkg::FracW){hist.prev_drive[ipc_pkg::ValW-1]}},
					hist.prev_drive, {ipc_pkg::FracW{1'b0}}};
		end
	end

	assign hi_lim = {{(ipc_pkg::AccW - ipc_pkg::ValW - ipc_pkg::FracW){cfg.out_max[ipc_pkg::ValW-1]}},
		cfg.out_max, {ipc_pkg::FracW{1'b0}}};
	assign lo_lim = {{(ipc_pkg::AccW - ipc_pkg::ValW - ipc_pkg::FracW){cfg.out_min[ipc_pkg::ValW-1]}},
		cfg.out_min, {ipc_pkg::FracW{1'b0}}};

	// round toward zero: negative sums with a fraction step up by one
	assign whole = acc[ipc_pkg::AccW-1:ipc_pkg::FracW];
	assign whole_tz = (acc[ipc_pkg::AccW-1] && (acc[ipc_pkg::FracW-1:0] != '0)) ?
		whole + {{(ipc_pkg::AccW-ipc_pkg::FracW-1){1'b0}}, 1'b1} : whole;

	always_comb begin
		priority if (acc > hi_lim) begin
			drive = cfg.out_max;
		end else if (acc < lo_lim) begin
			drive = cfg.out_min;
		end else begin
			drive = whole_tz[ipc_pkg::ValW-1:0];
		end
	end

endmodule

// ===== src/incremental_pi_controller_core.sv =====
// ----------------------------------------------------------------------------
// incremental_pi_controller_core
// incremental pi controller with registered input stage and output register
// ----------------------------------------------------------------------------
// One measured sample per transaction in, one clamped drive value per
// transaction out. Throughput is one sample per clock unless m_axis_tready
// stalls the output; a sample goes through the error register, then the
// result register behind the control law. The stored history is updated as
// the result is registered, so the next sample already sees it. Gains, setpoint
// and limits are written via the cfg channel; the user must write them only
// while the block holds no sample (not enforced); cfg_ready is always high.
module incremental_pi_controller_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ipc_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [ipc_pkg::CfgDataW-1:0]      cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [15:0]                       s_axis_tdata,  // [15:0] measured
	input  logic                              s_axis_tuser,  // [0] restart
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [15:0]                       m_axis_tdata   // [15:0] drive
);

	ipc_pkg::ipc_cfg_t                  cfg_q;
	ipc_pkg::ipc_hist_t                 hist_q;
	logic                               valid_s1;
	logic signed [ipc_pkg::ErrW-1:0]    err_s1;
	logic                               restart_s1;
	logic signed [ipc_pkg::ValW-1:0]    drive_q;
	logic signed [ipc_pkg::ValW-1:0]    drive_nxt;
	logic                               out_valid_q;
	logic                               advance;
	logic                               in_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp       <= '0;
			cfg_q.ki_ts    <= '0;
			cfg_q.setpoint <= '0;
			cfg_q.out_min  <= ipc_pkg::OutMinReset;
			cfg_q.out_max  <= ipc_pkg::OutMaxReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ipc_pkg::RegKp:       cfg_q.kp       <= cfg_data;
				ipc_pkg::RegKiTs:     cfg_q.ki_ts    <= cfg_data;
				ipc_pkg::RegSetpoint: cfg_q.setpoint <= cfg_data[ipc_pkg::ValW-1:0];
				ipc_pkg::RegOutMin:   cfg_q.out_min  <= cfg_data[ipc_pkg::ValW-1:0];
				ipc_pkg::RegOutMax:   cfg_q.out_max  <= cfg_data[ipc_pkg::ValW-1:0];
				default: ;
			endcase
		end
	end

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// input stage: error against the setpoint
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			err_s1     <= {cfg_q.setpoint[ipc_pkg::ValW-1], cfg_q.setpoint}
				- {s_axis_tdata[ipc_pkg::ValW-1], s_axis_tdata};
			restart_s1 <= s_axis_tuser;
		end
	end

	ipc_calc u_calc (
		.cfg     (cfg_q),
		.hist    (hist_q),
		.err     (err_s1),
		.restart (restart_s1),
		.drive   (drive_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				hist_q.prev_error <= err_s1;
				hist_q.prev_drive <= drive_nxt;
				hist_q.primed     <= 1'b1;
				out_valid_q       <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q <= drive_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = drive_q;

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (m_axis_tvalid && m_axis_tdata == hist_q.prev_drive))
		else $error("result register and stored drive disagree");

	a_primed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> hist_q.primed)
		else $error("result shown without history update");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (cfg_q.out_min <= cfg_q.out_max)) |->
		(($signed(m_axis_tdata) >= cfg_q.out_min) && ($signed(m_axis_tdata) <= cfg_q.out_max)))
		else $error("drive outside limits");

endmodule
